// File: rtl/core/vfc_pkg.sv
// ============================================================================
// vfc_pkg: shared types and constants of the voxel face culler
// Beat structs for the command and result channels, action and face codes,
// sequencer states, the fixed field widths and the vertex counter limits.
// ============================================================================
package vfc_pkg;

  // Fixed field widths
  localparam int IDX_W   = 12;
  localparam int ID_W    = 8;
  localparam int COORD_W = 4;
  localparam int FACE_W  = 3;
  localparam int VB_W    = 20;
  localparam int MUL_W   = 2 * IDX_W;

  // Vertex counter limits
  localparam logic [VB_W-1:0] COUNTER_TOP    = 20'hFFFFF;
  localparam logic [VB_W-1:0] VERTS_PER_FACE = 20'd4;

  // Command codes
  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_QUERY   = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  // Face directions, in test order
  typedef enum logic [FACE_W-1:0] {
    FACE_RIGHT  = 3'd0,
    FACE_TOP    = 3'd1,
    FACE_FRONT  = 3'd2,
    FACE_LEFT   = 3'd3,
    FACE_BOTTOM = 3'd4,
    FACE_BACK   = 3'd5
  } face_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } vfc_state_t;

  // Command beat
  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] block_index;
    logic [ID_W-1:0]  voxel_id;
  } vfc_in_t;

  // Result beat
  typedef struct packed {
    logic [COORD_W-1:0] block_x;
    logic [COORD_W-1:0] block_y;
    logic [COORD_W-1:0] block_z;
    logic [FACE_W-1:0]  face;
    logic [VB_W-1:0]    vertex_base;
    logic               visible;
    logic               last;
  } vfc_out_t;

endpackage

// File: rtl/core/voxel_face_culler.sv
// ============================================================================
// voxel_face_culler: face-culling mesher for one voxel chunk
// Holds the chunk's block ids in a one-read-port store, splits a query index
// into x, y and z on one shared multiplier and emits the visible faces.
// ============================================================================
// After reset the block sweeps its store to air, one entry a cycle, over
// min(WIDTH_X*HEIGHT_Y*DEPTH_Z, 4096) entries (4096 at the default size) with
// busy high. A command is taken when start is high and busy is low. A write
// or a restart acts in that same cycle and leaves busy low, so the next
// command may follow at once. A query holds busy high until its last result
// beat is shown and gives 1 to 6 results. The block is read on accept and
// its six neighbours are read in the scan through the one read port
// while the shared multiplier divides the index by WIDTH_X and DEPTH_Z, then
// one result beat a cycle is shown on out_data with out_strobe. Results
// cannot be held off, so take every beat in the cycle it is strobed.
module voxel_face_culler
  import vfc_pkg::*;
#(
  parameter int WIDTH_X  = 16,
  parameter int HEIGHT_Y = 16,
  parameter int DEPTH_Z  = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  vfc_in_t  in_data,
  output logic     out_strobe,
  output vfc_out_t out_data
);

  // Geometry
  localparam int CELL_COUNT  = WIDTH_X * HEIGHT_Y * DEPTH_Z;
  localparam int STORE_DEPTH = (CELL_COUNT < (1 << IDX_W)) ? CELL_COUNT : (1 << IDX_W);
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int NB_W        = IDX_W + 1;
  localparam int XW          = $clog2(WIDTH_X);
  localparam int ZW          = $clog2(DEPTH_Z);
  localparam int PLANE       = WIDTH_X * DEPTH_Z;
  localparam int RECIP_W     = (1 << IDX_W) / WIDTH_X;
  localparam int RECIP_D     = (1 << IDX_W) / DEPTH_Z;
  localparam logic [2:0] LAST_STEP = 3'd6;

  // Sequencer and datapath registers
  vfc_state_t        state_r, state_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  q_r, q_nxt;
  logic [XW-1:0]     x_r, x_nxt;
  logic [IDX_W-1:0]  y_r, y_nxt;
  logic [ZW-1:0]     z_r, z_nxt;
  logic [MUL_W-1:0]  prod_r, prod_nxt;
  logic              solid_r, solid_nxt;
  logic [4:0]        air_r, air_nxt;
  logic [5:0]        vis_r, vis_nxt;
  logic [VB_W-1:0]   cnt_r, cnt_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  vfc_out_t          out_data_r, out_data_nxt;
  logic              rd_oob_r, rd_oob_nxt;
  logic [ID_W-1:0]   rd_data_r;

  // Block store
  logic [ID_W-1:0]   mem [STORE_DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ID_W-1:0]   mem_wdata;
  logic [AW-1:0]     mem_raddr;

  // Shared multiplier and helpers
  logic [IDX_W-1:0]  mul_a, mul_b;
  logic [NB_W-1:0]   idx_ext, nb_idx;
  logic              nb_oob;
  logic              accept;
  logic              in_chunk;
  logic [IDX_W-1:0]  rem;
  logic              rem_ge;
  logic              air_now;
  logic [5:0]        edge_v;
  logic [5:0]        pick_oh;
  logic [FACE_W-1:0] pick_face;
  logic              pick_found;
  logic [5:0]        vis_left;
  logic [IDX_W-1:0]  x_wide, z_wide;
  logic [VB_W-1:0]   cnt_adv;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  assign idx_ext  = {1'b0, idx_r};
  assign in_chunk = ({1'b0, in_data.block_index} < NB_W'(STORE_DEPTH));
  assign air_now  = rd_oob_r || (rd_data_r == '0);
  assign x_wide   = IDX_W'(x_r);
  assign z_wide   = IDX_W'(z_r);
  assign cnt_adv  = (cnt_r > (COUNTER_TOP - VERTS_PER_FACE)) ? COUNTER_TOP
                                                             : cnt_r + VERTS_PER_FACE;

  // Remainder of the current division: dividend minus estimate times divisor
  assign rem = ((step_r == 3'd1) ? idx_r : q_r) - prod_r[IDX_W-1:0];

  // Neighbour address for the face read in this step
  always_comb begin
    case (step_r)
      FACE_RIGHT:  nb_idx = idx_ext + NB_W'(1);
      FACE_TOP:    nb_idx = idx_ext + NB_W'(PLANE);
      FACE_FRONT:  nb_idx = idx_ext + NB_W'(WIDTH_X);
      FACE_LEFT:   nb_idx = idx_ext - NB_W'(1);
      FACE_BOTTOM: nb_idx = idx_ext - NB_W'(PLANE);
      FACE_BACK:   nb_idx = idx_ext - NB_W'(WIDTH_X);
      default:     nb_idx = idx_ext;
    endcase
  end
  assign nb_oob = (nb_idx >= NB_W'(STORE_DEPTH));

  // Chunk borders, one bit per face in test order
  assign edge_v = {z_r == '0, y_r == '0, x_r == '0,
                   z_r == ZW'(DEPTH_Z - 1), y_r == IDX_W'(HEIGHT_Y - 1),
                   x_r == XW'(WIDTH_X - 1)};

  // Pick the lowest visible face still to send
  always_comb begin
    pick_oh    = '0;
    pick_face  = '0;
    pick_found = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (vis_r[i] && !pick_found) begin
        pick_found = 1'b1;
        pick_oh[i] = 1'b1;
        pick_face  = FACE_W'(i);
      end
    end
  end
  assign vis_left = vis_r & ~pick_oh;

  // Next state, store port, multiplier operands and result beat
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    clr_addr_nxt   = clr_addr_r;
    idx_nxt        = idx_r;
    q_nxt          = q_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    z_nxt          = z_r;
    solid_nxt      = solid_r;
    air_nxt        = air_r;
    vis_nxt        = vis_r;
    cnt_nxt        = cnt_r;
    rd_oob_nxt     = 1'b0;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = in_data.block_index[AW-1:0];
    mem_wdata      = in_data.voxel_id;
    mem_raddr      = in_data.block_index[AW-1:0];
    mul_a          = in_data.block_index;
    mul_b          = IDX_W'(RECIP_W);
    rem_ge         = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        // Sweep the store to air
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        // Own block is read and the x division started on every accept
        if (accept) begin
          case (in_data.action)
            ACT_WRITE: begin
              mem_we = in_chunk;
            end
            ACT_QUERY: begin
              idx_nxt   = in_data.block_index;
              step_nxt  = '0;
              state_nxt = ST_SCAN;
            end
            ACT_RESTART: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Read the six neighbours in face order while the multiplier splits the index
        mem_raddr  = nb_idx[AW-1:0];
        rd_oob_nxt = nb_oob;
        mul_a      = q_r;
        mul_b      = IDX_W'(WIDTH_X);
        step_nxt   = step_r + 3'd1;
        if (step_r != 3'd0) begin
          air_nxt = {air_now, air_r[4:1]};
        end
        case (step_r)
          3'd0: begin
            solid_nxt = ({1'b0, idx_r} < NB_W'(STORE_DEPTH)) && (rd_data_r != '0);
            q_nxt     = prod_r[MUL_W-1:IDX_W];
            mul_a     = prod_r[MUL_W-1:IDX_W];
          end
          3'd1: begin
            rem_ge = (rem >= IDX_W'(WIDTH_X));
            x_nxt  = rem_ge ? XW'(rem - IDX_W'(WIDTH_X)) : XW'(rem);
            q_nxt  = q_r + IDX_W'(rem_ge);
          end
          3'd2: begin
            mul_b = IDX_W'(RECIP_D);
          end
          3'd3: begin
            y_nxt = prod_r[MUL_W-1:IDX_W];
            mul_a = prod_r[MUL_W-1:IDX_W];
            mul_b = IDX_W'(DEPTH_Z);
          end
          3'd4: begin
            rem_ge = (rem >= IDX_W'(DEPTH_Z));
            z_nxt  = rem_ge ? ZW'(rem - IDX_W'(DEPTH_Z)) : ZW'(rem);
            y_nxt  = y_r + IDX_W'(rem_ge);
          end
          LAST_STEP: begin
            vis_nxt   = solid_r ? (edge_v | {air_now, air_r}) : 6'd0;
            state_nxt = ST_EMIT;
          end
          default: begin
          end
        endcase
      end

      ST_EMIT: begin
        // Send one face a cycle, or a single invisible beat
        out_strobe_nxt           = 1'b1;
        out_data_nxt.block_x     = x_wide[COORD_W-1:0];
        out_data_nxt.block_y     = y_r[COORD_W-1:0];
        out_data_nxt.block_z     = z_wide[COORD_W-1:0];
        out_data_nxt.vertex_base = cnt_r;
        if (pick_found) begin
          out_data_nxt.face    = pick_face;
          out_data_nxt.visible = 1'b1;
          out_data_nxt.last    = (vis_left == '0);
          vis_nxt              = vis_left;
          cnt_nxt              = cnt_adv;
          if (vis_left == '0) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          out_data_nxt.face    = FACE_RIGHT;
          out_data_nxt.visible = 1'b0;
          out_data_nxt.last    = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    prod_nxt = MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      step_r       <= '0;
      clr_addr_r   <= '0;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      clr_addr_r   <= clr_addr_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    q_r        <= q_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    prod_r     <= prod_nxt;
    solid_r    <= solid_nxt;
    air_r      <= air_nxt;
    vis_r      <= vis_nxt;
    rd_oob_r   <= rd_oob_nxt;
    out_data_r <= out_data_nxt;
  end

  // Store write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Store read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[mem_raddr];
  end

`ifndef SYNTHESIS
  // A beat only follows a cycle in the emit state
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == ST_EMIT))
    else $error("result beat outside emit phase");

  // An invisible beat is always the only and final one of its query
  a_invisible_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && !out_data_r.visible) |-> out_data_r.last)
    else $error("invisible beat not marked last");

  // The final beat releases the block
  a_last_releases: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_data_r.last) |-> (state_r == ST_IDLE))
    else $error("busy after final beat");

  // The counter never falls while a query runs
  a_counter_rises: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_EMIT) |=> (cnt_r >= $past(cnt_r)))
    else $error("vertex counter fell during a query");

  // A visible face below the top moves the counter on by one quad
  a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_data_r.visible && (out_data_r.vertex_base != COUNTER_TOP))
    |-> (cnt_r == ((out_data_r.vertex_base > (COUNTER_TOP - VERTS_PER_FACE)) ?
                   COUNTER_TOP : out_data_r.vertex_base + VERTS_PER_FACE)))
    else $error("vertex counter step wrong");
`endif

endmodule

// File: sim/voxel_face_culler_test.sv
`timescale 1ns / 1ps
// ============================================================================
// voxel_face_culler_test: self-checking bench for the voxel face culler
// Drives write, query, restart and unused commands through the start/busy
// handshake and keeps its own chunk and vertex counter. Each query's expected
// face beats are queued in order and every strobed result is compared field by
// field. Directed cases cover an empty chunk, corner blocks, a fully buried
// block, ignored commands and a run of exposed faces followed by a restart.
// Random phases exercise dense clusters with varied sender idling.
// ============================================================================
module voxel_face_culler_test;
  import vfc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  localparam int CHUNK_W      = 16;
  localparam int CHUNK_H      = 16;
  localparam int CHUNK_D      = 16;
  localparam int CELLS        = CHUNK_W * CHUNK_H * CHUNK_D;
  localparam int TAIL_CYCLES  = 20;
  localparam int RUN_LIMIT    = 100_000;
  // Six-face queries in a row before the counter is rewound
  localparam int SAT_QUERIES  = 6;
  // Command code the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  vfc_in_t  in_data = '0;
  logic     out_strobe;
  vfc_out_t out_data;

  // Shadow chunk, vertex counter and the face beats still to arrive
  logic [ID_W-1:0] chunk_ids [CELLS];
  logic [VB_W-1:0] next_vertex = '0;
  vfc_out_t        pending_faces [$];

  int err_count   = 0;
  int cycle_count = 0;
  int idle_pct    = 0;
  int cl_x, cl_y, cl_z;

  voxel_face_culler #(
    .WIDTH_X (CHUNK_W),
    .HEIGHT_Y(CHUNK_H),
    .DEPTH_Z (CHUNK_D)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int cell_index(input int x, input int y, input int z);
    return (y * CHUNK_D + z) * CHUNK_W + x;
  endfunction

  // Outside the chunk or air: the face towards it shows
  function automatic bit cell_open(input int x, input int y, input int z);
    if (x < 0 || x >= CHUNK_W || y < 0 || y >= CHUNK_H || z < 0 || z >= CHUNK_D)
      return 1'b1;
    return chunk_ids[cell_index(x, y, z)] == '0;
  endfunction

  // Apply one accepted command to the shadow state and queue its face beats
  function automatic void cull_faces(input vfc_in_t cmd);
    int       idx, x, y, z, nx, ny, nz, n;
    bit       solid;
    vfc_out_t beat;
    vfc_out_t found [6];
    idx = int'(cmd.block_index);
    n   = 0;
    case (cmd.action)
      ACT_WRITE: begin
        if (idx < CELLS) chunk_ids[idx] = cmd.voxel_id;
      end
      ACT_RESTART: begin
        next_vertex = '0;
      end
      ACT_QUERY: begin
        x = idx % CHUNK_W;
        z = (idx / CHUNK_W) % CHUNK_D;
        y = idx / (CHUNK_W * CHUNK_D);
        solid = idx < CELLS && chunk_ids[idx] != '0;
        beat.block_x = x[COORD_W-1:0];
        beat.block_y = y[COORD_W-1:0];
        beat.block_z = z[COORD_W-1:0];
        if (solid) begin
          for (int f = FACE_RIGHT; f <= FACE_BACK; f++) begin
            nx = x;
            ny = y;
            nz = z;
            case (f)
              FACE_RIGHT:  nx = x + 1;
              FACE_TOP:    ny = y + 1;
              FACE_FRONT:  nz = z + 1;
              FACE_LEFT:   nx = x - 1;
              FACE_BOTTOM: ny = y - 1;
              default:     nz = z - 1;
            endcase
            if (cell_open(nx, ny, nz)) begin
              beat.face        = face_t'(f);
              beat.vertex_base = next_vertex;
              beat.visible     = 1'b1;
              beat.last        = 1'b0;
              found[n]         = beat;
              n++;
              // Saturate at the top instead of wrapping
              if (next_vertex > COUNTER_TOP - VERTS_PER_FACE) next_vertex = COUNTER_TOP;
              else next_vertex = next_vertex + VERTS_PER_FACE;
            end
          end
        end
        if (n == 0) begin
          beat.face        = FACE_RIGHT;
          beat.vertex_base = next_vertex;
          beat.visible     = 1'b0;
          beat.last        = 1'b1;
          pending_faces = {pending_faces, beat};
        end else begin
          found[n-1].last = 1'b1;
          for (int i = 0; i < n; i++) pending_faces = {pending_faces, found[i]};
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endtask

  // Compare every strobed result beat with the oldest expectation
  always @(posedge clk) begin : check_beat
    vfc_out_t want;
    if (rst_n && out_strobe) begin
      if (pending_faces.size() == 0) begin
        $error("result beat with none expected: %p", out_data);
        err_count++;
      end else begin
        want = pending_faces.pop_front();
        check_field("block_x",     want.block_x,     out_data.block_x);
        check_field("block_y",     want.block_y,     out_data.block_y);
        check_field("block_z",     want.block_z,     out_data.block_z);
        check_field("face",        want.face,        out_data.face);
        check_field("vertex_base", want.vertex_base, out_data.vertex_base);
        check_field("visible",     want.visible,     out_data.visible);
        check_field("last",        want.last,        out_data.last);
      end
    end
  end

  // Send one command beat, idling first at the current rate
  task automatic send_cmd(input logic [1:0] act, input int idx, input int id);
    vfc_in_t cmd;
    cmd.action      = act;
    cmd.block_index = idx[IDX_W-1:0];
    cmd.voxel_id    = id[ID_W-1:0];
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
    cull_faces(cmd);
  endtask

  // Hold off until every expected beat has arrived
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_faces.size() != 0);
  endtask

  task automatic test_empty_chunk();
    send_cmd(ACT_QUERY, 0, 0);
    send_cmd(ACT_QUERY, CELLS - 1, 0);
  endtask

  // Lone blocks at opposite corners show all six faces
  task automatic test_corner_blocks();
    send_cmd(ACT_WRITE, 0, 255);
    send_cmd(ACT_QUERY, 0, 0);
    send_cmd(ACT_WRITE, CELLS - 1, 1);
    send_cmd(ACT_QUERY, CELLS - 1, 0);
  endtask

  // A block with all six neighbours solid shows nothing
  task automatic test_buried_block();
    send_cmd(ACT_WRITE, cell_index(5, 5, 5), 7);
    send_cmd(ACT_WRITE, cell_index(6, 5, 5), $urandom_range(1, 255));
    send_cmd(ACT_WRITE, cell_index(5, 6, 5), $urandom_range(1, 255));
    send_cmd(ACT_WRITE, cell_index(5, 5, 6), $urandom_range(1, 255));
    send_cmd(ACT_WRITE, cell_index(4, 5, 5), $urandom_range(1, 255));
    send_cmd(ACT_WRITE, cell_index(5, 4, 5), $urandom_range(1, 255));
    send_cmd(ACT_WRITE, cell_index(5, 5, 4), $urandom_range(1, 255));
    send_cmd(ACT_QUERY, cell_index(5, 5, 5), 0);
    send_cmd(ACT_QUERY, cell_index(6, 5, 5), 0);
  endtask

  // Unused code changes nothing; restart rewinds the counter; air clears
  task automatic test_ignored_and_restart();
    send_cmd(ACT_UNUSED, cell_index(5, 5, 5), 0);
    send_cmd(ACT_QUERY, cell_index(5, 5, 5), 0);
    send_cmd(ACT_RESTART, $urandom_range(CELLS - 1), $urandom_range(255));
    send_cmd(ACT_QUERY, 0, 0);
    send_cmd(ACT_WRITE, 0, 0);
    send_cmd(ACT_QUERY, 0, 0);
  endtask

  // Mostly a small cluster so queries see mixed neighbours; some anywhere
  function automatic int pick_index();
    if ($urandom_range(99) < 25) return $urandom_range(CELLS - 1);
    return cell_index(cl_x + $urandom_range(3), cl_y + $urandom_range(3),
                      cl_z + $urandom_range(3));
  endfunction

  task automatic test_random_phase(input int pct, input int n_items);
    int sent, pick;
    sent     = 0;
    idle_pct = pct;
    cl_x = ($urandom_range(2) == 0) ? 0 : $urandom_range(CHUNK_W - 4);
    cl_y = ($urandom_range(2) == 0) ? CHUNK_H - 4 : $urandom_range(CHUNK_H - 4);
    cl_z = $urandom_range(CHUNK_D - 4);
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_cmd(ACT_WRITE, pick_index(),
                 ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 255));
        sent++;
      end else if (pick < 90) begin
        send_cmd(ACT_QUERY, pick_index(), $urandom_range(255));
        sent++;
      end else if (pick < 95) begin
        send_cmd(ACT_RESTART, $urandom_range(CELLS - 1), $urandom_range(255));
        sent++;
      end else begin
        send_cmd(ACT_UNUSED, $urandom_range(CELLS - 1), $urandom_range(255));
      end
    end
    wait_drained();
  endtask

  // Run an exposed block's faces back to back, then rewind
  task automatic test_counter_rewind();
    idle_pct = 0;
    send_cmd(ACT_WRITE, cell_index(9, 8, 8), 0);
    send_cmd(ACT_WRITE, cell_index(8, 9, 8), 0);
    send_cmd(ACT_WRITE, cell_index(8, 8, 9), 0);
    send_cmd(ACT_WRITE, cell_index(7, 8, 8), 0);
    send_cmd(ACT_WRITE, cell_index(8, 7, 8), 0);
    send_cmd(ACT_WRITE, cell_index(8, 8, 7), 0);
    send_cmd(ACT_WRITE, cell_index(8, 8, 8), 200);
    send_cmd(ACT_RESTART, 0, 0);
    repeat (SAT_QUERIES) send_cmd(ACT_QUERY, cell_index(8, 8, 8), 0);
    send_cmd(ACT_QUERY, cell_index(9, 8, 8), 0);
    send_cmd(ACT_RESTART, 0, 0);
    send_cmd(ACT_QUERY, cell_index(8, 8, 8), 0);
  endtask

  initial begin
    foreach (chunk_ids[i]) chunk_ids[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_chunk();
    test_corner_blocks();
    test_buried_block();
    test_ignored_and_restart();
    wait_drained();

    test_random_phase(0, 70);
    test_random_phase(51, 70);
    test_random_phase(30, 70);

    test_counter_rewind();

    // Let any stray beats surface before the verdict
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_faces.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
